// ===== design/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// shared types and constants of the chained hash multimap
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int POOL_DEPTH  = 1024;
    localparam int MAX_REPORT  = 64;

    localparam int LINK_W = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W  = $clog2(POOL_DEPTH);
    localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int DIV_W  = $clog2(MAX_BUCKETS + 1);
    localparam int CNT_W  = 11;
    localparam int LIM_W  = 7;

    typedef logic [LINK_W-1:0] t_link;

    localparam t_link NIL_LINK = t_link'(POOL_DEPTH);

    localparam logic [1:0] K_INSERT = 2'd0;
    localparam logic [1:0] K_LOOKUP = 2'd1;
    localparam logic [1:0] K_ERASE  = 2'd2;

    localparam logic [31:0] HASH_MULT = 32'h27d4eb2d;
    localparam logic [31:0] HASH_XOR  = 32'd61;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      key;
        logic [31:0]      value;
        logic [LIM_W-1:0] report_limit;
    } t_req;

    typedef struct packed {
        logic             status;
        logic [31:0]      found_value;
        logic             value_valid;
        logic [CNT_W-1:0] match_count;
        logic             last;
    } t_rsp;

endpackage

// ===== design/chm_hash.sv =====
// ----------------------------------------------------------------------------
// chm_hash
// iterative integer hash of a key followed by a bit-serial modulo
// ----------------------------------------------------------------------------
module chm_hash (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [31:0]               i_key,
    input  logic [chm_pkg::DIV_W-1:0] i_div,
    output logic                      o_done,
    output logic [chm_pkg::BKT_W-1:0] o_bucket
);

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_MIX1 = 3'd1;
    localparam logic [2:0] P_MIX2 = 3'd2;
    localparam logic [2:0] P_MIX3 = 3'd3;
    localparam logic [2:0] P_MUL  = 3'd4;
    localparam logic [2:0] P_MIX5 = 3'd5;
    localparam logic [2:0] P_MOD  = 3'd6;

    logic [2:0]                r_phase, n_phase;
    logic [31:0]               r_w, n_w;
    logic [4:0]                r_bit, n_bit;
    logic [chm_pkg::DIV_W-1:0] r_rem, n_rem;
    logic                      r_done, n_done;
    logic [chm_pkg::DIV_W:0]   shifted;

    assign shifted = {r_rem, r_w[r_bit]};

    always_comb begin
        n_phase = r_phase;
        n_w     = r_w;
        n_bit   = r_bit;
        n_rem   = r_rem;
        n_done  = 1'b0;
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_w     = i_key;
                    n_phase = P_MIX1;
                end
            end
            P_MIX1: begin
                n_w     = (r_w ^ chm_pkg::HASH_XOR) ^ (r_w >> 16);
                n_phase = P_MIX2;
            end
            P_MIX2: begin
                n_w     = r_w + (r_w << 3);
                n_phase = P_MIX3;
            end
            P_MIX3: begin
                n_w     = r_w ^ (r_w >> 4);
                n_phase = P_MUL;
            end
            P_MUL: begin
                n_w     = r_w * chm_pkg::HASH_MULT;
                n_phase = P_MIX5;
            end
            P_MIX5: begin
                n_w     = r_w ^ (r_w >> 15);
                n_bit   = 5'd31;
                n_rem   = '0;
                n_phase = P_MOD;
            end
            P_MOD: begin
                // restoring step, remainder stays below the divisor
                if (shifted >= {1'b0, i_div}) begin
                    n_rem = chm_pkg::DIV_W'(shifted - {1'b0, i_div});
                end else begin
                    n_rem = chm_pkg::DIV_W'(shifted);
                end
                n_bit = r_bit - 5'd1;
                if (r_bit == 5'd0) begin
                    n_done  = 1'b1;
                    n_phase = P_IDLE;
                end
            end
            default: n_phase = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_w   <= n_w;
        r_bit <= n_bit;
        r_rem <= n_rem;
    end

    assign o_done   = r_done;
    assign o_bucket = r_rem[chm_pkg::BKT_W-1:0];

endmodule

// ===== design/chained_hash_multimap.sv =====
// insert hashes the key, reads the bucket head and links a node there (after a free list pop
// when a freed node is reused); lookup and erase walk the chain, and output stalls add waits
// the hash unit runs five mixing steps and a 32-step bit-serial modulo
// one request at a time: o_req_stall is high from acceptance until the last result is queued
// synchronous active-low reset empties all buckets, the free list and the pool mark,
// and sets the bucket count to 64; no clearing pass is needed
// ----------------------------------------------------------------------------
// chained_hash_multimap
// multimap of 32-bit keys to 32-bit values with chained buckets in a node pool
// ----------------------------------------------------------------------------
module chained_hash_multimap (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_stall,
    input  chm_pkg::t_req             i_req,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_stall,
    output chm_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_we,
    input  logic [chm_pkg::LIM_W-1:0] i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a request
    localparam logic [3:0] S_HASH = 4'd1;  // hash unit running
    localparam logic [3:0] S_RDH  = 4'd2;  // bucket head read in flight
    localparam logic [3:0] S_HEAD = 4'd3;  // bucket head available
    localparam logic [3:0] S_POP  = 4'd4;  // free list next link available
    localparam logic [3:0] S_RD   = 4'd5;  // issue node read
    localparam logic [3:0] S_CHK  = 4'd6;  // compare node key
    localparam logic [3:0] S_UNL  = 4'd7;  // unlink matched node
    localparam logic [3:0] S_FREE = 4'd8;  // push matched node on free list
    localparam logic [3:0] S_FIN  = 4'd9;  // queue the final result

    // configuration
    logic [chm_pkg::LIM_W-1:0] r_bcnt;
    logic [chm_pkg::DIV_W-1:0] div_n;

    // control state
    logic [3:0]                r_state, n_state;
    chm_pkg::t_req             r_req, n_req;
    logic [chm_pkg::LIM_W-1:0] r_lim, n_lim;
    logic [chm_pkg::BKT_W-1:0] r_b, n_b;
    chm_pkg::t_link            r_cur, n_cur;
    chm_pkg::t_link            r_prev, n_prev;
    chm_pkg::t_link            r_steps, n_steps;
    logic [chm_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [chm_pkg::LIM_W-1:0] r_rep, n_rep;
    logic                      r_pend, n_pend;
    logic [31:0]               r_pval, n_pval;
    chm_pkg::t_link            r_free, n_free;
    chm_pkg::t_link            r_fresh, n_fresh;
    logic                      r_status, n_status;

    // output register
    logic                      r_ovld, n_ovld;
    chm_pkg::t_rsp             r_orsp, n_orsp;
    logic                      can_emit;

    // hash unit
    logic                      h_start;
    logic                      h_done;
    logic [chm_pkg::BKT_W-1:0] h_bucket;
    // tracks whether the hash unit has been started for this request
    logic                      r_hbusy;

    // bucket head memory, valid bits stand in for the reset clear
    logic [chm_pkg::LINK_W-1:0] bh_mem [chm_pkg::MAX_BUCKETS];
    logic [chm_pkg::MAX_BUCKETS-1:0] r_bh_vld;
    chm_pkg::t_link            r_bh_q;
    logic                      r_bhv_q;
    logic                      bh_we;
    chm_pkg::t_link            bh_wd;
    chm_pkg::t_link            head;

    // node pool memories
    logic [31:0]               nk_mem [chm_pkg::POOL_DEPTH];
    logic [31:0]               nv_mem [chm_pkg::POOL_DEPTH];
    logic [chm_pkg::LINK_W-1:0] nn_mem [chm_pkg::POOL_DEPTH];
    logic [31:0]               r_key_q;
    logic [31:0]               r_val_q;
    chm_pkg::t_link            r_nxt_q;
    logic                      rd_en;
    logic [chm_pkg::IDX_W-1:0] rd_addr;
    logic                      kv_we;
    logic [chm_pkg::IDX_W-1:0] kv_wa;
    logic                      nn_we;
    logic [chm_pkg::IDX_W-1:0] nn_wa;
    chm_pkg::t_link            nn_wd;
    logic                      key_hit;

    // bucket count of zero acts as one, large counts saturate
    always_comb begin
        if (r_bcnt == '0) begin
            div_n = chm_pkg::DIV_W'(1);
        end else if (r_bcnt > chm_pkg::LIM_W'(chm_pkg::MAX_BUCKETS)) begin
            div_n = chm_pkg::DIV_W'(chm_pkg::MAX_BUCKETS);
        end else begin
            div_n = chm_pkg::DIV_W'(r_bcnt);
        end
    end

    chm_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (h_start),
        .i_key    (r_req.key),
        .i_div    (div_n),
        .o_done   (h_done),
        .o_bucket (h_bucket)
    );

    assign head     = r_bhv_q ? r_bh_q : chm_pkg::NIL_LINK;
    assign key_hit  = (r_key_q == r_req.key);
    assign can_emit = !r_ovld || !i_rsp_stall;

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_lim    = r_lim;
        n_b      = r_b;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_cnt    = r_cnt;
        n_rep    = r_rep;
        n_pend   = r_pend;
        n_pval   = r_pval;
        n_free   = r_free;
        n_fresh  = r_fresh;
        n_status = r_status;
        n_ovld   = r_ovld && i_rsp_stall;
        n_orsp   = r_orsp;
        h_start  = 1'b0;
        bh_we    = 1'b0;
        bh_wd    = chm_pkg::NIL_LINK;
        rd_en    = 1'b0;
        rd_addr  = r_cur[chm_pkg::IDX_W-1:0];
        kv_we    = 1'b0;
        kv_wa    = r_fresh[chm_pkg::IDX_W-1:0];
        nn_we    = 1'b0;
        nn_wa    = r_fresh[chm_pkg::IDX_W-1:0];
        nn_wd    = head;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req    = i_req;
                    n_cnt    = '0;
                    n_rep    = '0;
                    n_pend   = 1'b0;
                    n_steps  = '0;
                    n_prev   = chm_pkg::NIL_LINK;
                    n_status = 1'b0;
                    // report limit of zero acts as one, large limits saturate
                    if (i_req.report_limit == '0) begin
                        n_lim = chm_pkg::LIM_W'(1);
                    end else if (i_req.report_limit > chm_pkg::LIM_W'(chm_pkg::MAX_REPORT)) begin
                        n_lim = chm_pkg::LIM_W'(chm_pkg::MAX_REPORT);
                    end else begin
                        n_lim = i_req.report_limit;
                    end
                    if (i_req.kind inside {chm_pkg::K_INSERT, chm_pkg::K_LOOKUP,
                                           chm_pkg::K_ERASE}) begin
                        n_state = S_HASH;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_HASH: begin
                // start pulses on the first hash cycle only
                h_start = !r_hbusy;
                if (h_done) begin
                    n_b     = h_bucket;
                    n_state = S_RDH;
                end
            end
            S_RDH: begin
                n_state = S_HEAD;
            end
            S_HEAD: begin
                if (r_req.kind == chm_pkg::K_INSERT) begin
                    if (r_free != chm_pkg::NIL_LINK) begin
                        // fetch the link of the free list head
                        rd_en   = 1'b1;
                        rd_addr = r_free[chm_pkg::IDX_W-1:0];
                        n_state = S_POP;
                    end else if (r_fresh != chm_pkg::NIL_LINK) begin
                        kv_we   = 1'b1;
                        kv_wa   = r_fresh[chm_pkg::IDX_W-1:0];
                        nn_we   = 1'b1;
                        nn_wa   = r_fresh[chm_pkg::IDX_W-1:0];
                        nn_wd   = head;
                        bh_we   = 1'b1;
                        bh_wd   = r_fresh;
                        n_fresh = r_fresh + chm_pkg::LINK_W'(1);
                        n_state = S_FIN;
                    end else begin
                        // pool full, refuse
                        n_status = 1'b1;
                        n_state  = S_FIN;
                    end
                end else begin
                    n_cur   = head;
                    n_state = S_RD;
                end
            end
            S_POP: begin
                kv_we   = 1'b1;
                kv_wa   = r_free[chm_pkg::IDX_W-1:0];
                nn_we   = 1'b1;
                nn_wa   = r_free[chm_pkg::IDX_W-1:0];
                nn_wd   = head;
                bh_we   = 1'b1;
                bh_wd   = r_free;
                n_free  = r_nxt_q;
                n_state = S_FIN;
            end
            S_RD: begin
                if (r_cur == chm_pkg::NIL_LINK
                    || r_steps == chm_pkg::t_link'(chm_pkg::POOL_DEPTH)) begin
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_cur[chm_pkg::IDX_W-1:0];
                    n_steps = r_steps + chm_pkg::LINK_W'(1);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_req.kind == chm_pkg::K_LOOKUP) begin
                    if (key_hit && r_rep < r_lim) begin
                        if (!r_pend || can_emit) begin
                            // older pending value goes out as a non-final item
                            if (r_pend) begin
                                n_ovld = 1'b1;
                                n_orsp = '{status: 1'b0, found_value: r_pval, value_valid: 1'b1,
                                           match_count: '0, last: 1'b0};
                            end
                            n_pend  = 1'b1;
                            n_pval  = r_val_q;
                            n_rep   = r_rep + chm_pkg::LIM_W'(1);
                            n_cnt   = r_cnt + chm_pkg::CNT_W'(1);
                            n_cur   = r_nxt_q;
                            n_state = S_RD;
                        end
                    end else begin
                        if (key_hit) begin
                            n_cnt = r_cnt + chm_pkg::CNT_W'(1);
                        end
                        n_cur   = r_nxt_q;
                        n_state = S_RD;
                    end
                end else begin
                    if (key_hit) begin
                        n_state = S_UNL;
                    end else begin
                        n_prev  = r_cur;
                        n_cur   = r_nxt_q;
                        n_state = S_RD;
                    end
                end
            end
            S_UNL: begin
                if (r_prev != chm_pkg::NIL_LINK) begin
                    nn_we = 1'b1;
                    nn_wa = r_prev[chm_pkg::IDX_W-1:0];
                    nn_wd = r_nxt_q;
                end else begin
                    bh_we = 1'b1;
                    bh_wd = r_nxt_q;
                end
                n_state = S_FREE;
            end
            S_FREE: begin
                nn_we   = 1'b1;
                nn_wa   = r_cur[chm_pkg::IDX_W-1:0];
                nn_wd   = r_free;
                n_free  = r_cur;
                n_cnt   = r_cnt + chm_pkg::CNT_W'(1);
                n_cur   = r_nxt_q;
                n_state = S_RD;
            end
            S_FIN: begin
                if (can_emit) begin
                    n_ovld = 1'b1;
                    n_orsp = '{status: r_status, found_value: r_pend ? r_pval : 32'd0,
                               value_valid: r_pend, match_count: r_cnt, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hbusy <= 1'b0;
        end else if (h_start) begin
            r_hbusy <= 1'b1;
        end else if (h_done) begin
            r_hbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bcnt   <= chm_pkg::LIM_W'(chm_pkg::MAX_BUCKETS);
            r_free   <= chm_pkg::NIL_LINK;
            r_fresh  <= '0;
            r_ovld   <= 1'b0;
            r_cnt    <= '0;
            r_rep    <= '0;
            r_pend   <= 1'b0;
            r_steps  <= '0;
            r_prev   <= chm_pkg::NIL_LINK;
            r_status <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_fresh  <= n_fresh;
            r_ovld   <= n_ovld;
            r_cnt    <= n_cnt;
            r_rep    <= n_rep;
            r_pend   <= n_pend;
            r_steps  <= n_steps;
            r_prev   <= n_prev;
            r_status <= n_status;
            if (i_cfg_we) begin
                r_bcnt <= i_cfg_data;
            end
        end
        r_req  <= n_req;
        r_lim  <= n_lim;
        r_b    <= n_b;
        r_cur  <= n_cur;
        r_pval <= n_pval;
        r_orsp <= n_orsp;
    end

    // bucket heads: one write port, one registered read at the current bucket
    always_ff @(posedge i_clk) begin
        if (bh_we) begin
            bh_mem[r_b] <= bh_wd;
        end
        r_bh_q <= bh_mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bh_vld <= '0;
            r_bhv_q  <= 1'b0;
        end else begin
            if (bh_we) begin
                r_bh_vld[r_b] <= 1'b1;
            end
            r_bhv_q <= r_bh_vld[r_b];
        end
    end

    // node pool: key and value share a write address, links have their own
    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            nk_mem[kv_wa] <= r_req.key;
            nv_mem[kv_wa] <= r_req.value;
        end
        if (rd_en) begin
            r_key_q <= nk_mem[rd_addr];
            r_val_q <= nv_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nn_we) begin
            nn_mem[nn_wa] <= nn_wd;
        end
        if (rd_en) begin
            r_nxt_q <= nn_mem[rd_addr];
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_ovld;
    assign o_rsp       = r_orsp;

endmodule

// ===== design/chm_checker.sv =====
// ----------------------------------------------------------------------------
// chm_checker
// port-level checks on the result channel of the hash multimap
// ----------------------------------------------------------------------------
module chm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_rsp_stall,
    input logic          o_rsp_valid,
    input chm_pkg::t_rsp o_rsp
);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // pool-full refusal is always a final item
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status |-> o_rsp.last && !o_rsp.value_valid)
        else $error("refusal not on a final item");

    // non-final items carry a value and no count
    a_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.last |-> o_rsp.value_valid && o_rsp.match_count == '0)
        else $error("bad non-final item");

    // no value reported means a zero value field
    a_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp.value_valid |-> o_rsp.found_value == 32'd0)
        else $error("value without valid flag");

endmodule

bind chained_hash_multimap chm_checker u_chm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp)
);

// ===== sim/tb_chained_hash_multimap.sv =====
// ----------------------------------------------------------------------------
// tb_chained_hash_multimap
// self-checking bench for the chained hash multimap: a scoreboard keeps its
// own buckets and node pool, predicts every result of each accepted request
// and compares the block's results field by field, under several idle and
// stall patterns and bucket counts
// ----------------------------------------------------------------------------
module tb_chained_hash_multimap;
    timeunit 1ns;
    timeprecision 1ps;

    // no operation code in the package for the unused kind
    localparam logic [1:0] K_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 80;

    // keeps a private copy of the table and the queue of awaited results
    class hash_multimap_scoreboard;
        logic [31:0]   node_keys[chm_pkg::POOL_DEPTH];
        logic [31:0]   node_vals[chm_pkg::POOL_DEPTH];
        int            node_links[chm_pkg::POOL_DEPTH];
        int            chain_heads[chm_pkg::MAX_BUCKETS];
        int            free_head;
        int            fresh_mark;
        int            live_nodes;
        int            bucket_sel;
        chm_pkg::t_rsp awaited[$];
        int            errors;
        int            results_seen;
        int            refusals;
        int            erased_total;
        int            reported_values;

        function new();
            for (int i = 0; i < chm_pkg::MAX_BUCKETS; i++) chain_heads[i] = chm_pkg::POOL_DEPTH;
            free_head = chm_pkg::POOL_DEPTH;
            fresh_mark = 0;
            live_nodes = 0;
            bucket_sel = 64;
            errors = 0;
            results_seen = 0;
            refusals = 0;
            erased_total = 0;
            reported_values = 0;
        endfunction

        function void set_buckets(logic [chm_pkg::LIM_W-1:0] n);
            bucket_sel = n;
        endfunction

        function int bucket_for(logic [31:0] k);
            int n;
            n = bucket_sel;
            if (n == 0) n = 1;
            if (n > chm_pkg::MAX_BUCKETS) n = chm_pkg::MAX_BUCKETS;
            k = (k ^ chm_pkg::HASH_XOR) ^ (k >> 16);
            k = k + (k << 3);
            k = k ^ (k >> 4);
            k = k * chm_pkg::HASH_MULT;
            k = k ^ (k >> 15);
            return int'(k % 32'(n));
        endfunction

        function void push(logic st, logic [31:0] v, logic vv, int cnt, logic lst);
            chm_pkg::t_rsp r;
            r.status = st;
            r.found_value = v;
            r.value_valid = vv;
            r.match_count = chm_pkg::CNT_W'(cnt);
            r.last = lst;
            awaited.push_back(r);
        endfunction

        // work out the results of one accepted request
        function void note(chm_pkg::t_req q);
            int b, cur, nxt, prev, n, cnt, lim, steps;
            logic [31:0] found[$];
            lim = q.report_limit;
            if (lim == 0) lim = 1;
            if (lim > chm_pkg::MAX_REPORT) lim = chm_pkg::MAX_REPORT;
            case (q.kind)
                chm_pkg::K_INSERT: begin
                    b = bucket_for(q.key);
                    if (free_head < chm_pkg::POOL_DEPTH) begin
                        n = free_head;
                        free_head = node_links[n];
                    end else if (fresh_mark < chm_pkg::POOL_DEPTH) begin
                        n = fresh_mark;
                        fresh_mark++;
                    end else begin
                        refusals++;
                        push(1'b1, '0, 1'b0, 0, 1'b1);
                        return;
                    end
                    node_keys[n] = q.key;
                    node_vals[n] = q.value;
                    node_links[n] = chain_heads[b];
                    chain_heads[b] = n;
                    live_nodes++;
                    push(1'b0, '0, 1'b0, 0, 1'b1);
                end
                chm_pkg::K_LOOKUP: begin
                    b = bucket_for(q.key);
                    cur = chain_heads[b];
                    cnt = 0;
                    steps = 0;
                    while (cur < chm_pkg::POOL_DEPTH && steps < chm_pkg::POOL_DEPTH) begin
                        if (node_keys[cur] == q.key) begin
                            if (found.size() < lim) found.push_back(node_vals[cur]);
                            cnt++;
                        end
                        cur = node_links[cur];
                        steps++;
                    end
                    if (found.size() == 0) begin
                        push(1'b0, '0, 1'b0, cnt, 1'b1);
                    end else begin
                        reported_values += found.size();
                        foreach (found[i]) begin
                            if (i == found.size() - 1) push(1'b0, found[i], 1'b1, cnt, 1'b1);
                            else push(1'b0, found[i], 1'b1, 0, 1'b0);
                        end
                    end
                end
                chm_pkg::K_ERASE: begin
                    b = bucket_for(q.key);
                    cur = chain_heads[b];
                    prev = chm_pkg::POOL_DEPTH;
                    cnt = 0;
                    steps = 0;
                    while (cur < chm_pkg::POOL_DEPTH && steps < chm_pkg::POOL_DEPTH) begin
                        nxt = node_links[cur];
                        if (node_keys[cur] == q.key) begin
                            if (prev < chm_pkg::POOL_DEPTH) node_links[prev] = nxt;
                            else chain_heads[b] = nxt;
                            node_links[cur] = free_head;
                            free_head = cur;
                            if (live_nodes > 0) live_nodes--;
                            cnt++;
                        end else begin
                            prev = cur;
                        end
                        cur = nxt;
                        steps++;
                    end
                    erased_total += cnt;
                    push(1'b0, '0, 1'b0, cnt, 1'b1);
                end
                default: begin
                    push(1'b0, '0, 1'b0, 0, 1'b1);
                end
            endcase
        endfunction

        // compare one accepted result against the oldest awaited one
        function void check(chm_pkg::t_rsp got);
            chm_pkg::t_rsp exp;
            results_seen++;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: %p", got);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.found_value !== exp.found_value) begin
                $error("found_value: expected %h, got %h", exp.found_value, got.found_value);
                errors++;
            end
            if (got.value_valid !== exp.value_valid) begin
                $error("value_valid: expected %0d, got %0d", exp.value_valid, got.value_valid);
                errors++;
            end
            if (got.match_count !== exp.match_count) begin
                $error("match_count: expected %0d, got %0d", exp.match_count, got.match_count);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_req_valid;
    logic                      o_req_stall;
    chm_pkg::t_req             i_req;
    logic                      o_rsp_valid;
    logic                      i_rsp_stall;
    chm_pkg::t_rsp             o_rsp;
    logic                      i_cfg_we;
    logic [chm_pkg::LIM_W-1:0] i_cfg_data;

    hash_multimap_scoreboard sb = new();

    // chance in a hundred that the sender idles after a request / the receiver stalls
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int requests_sent = 0;

    // small set of keys so lookups and erases actually hit
    logic [31:0] hot_keys[12];

    chained_hash_multimap DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #100ms;
        $display("simulation failed");
        $finish;
    end

    // result side: sample before this edge's updates land, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) sb.check(o_rsp);
        i_rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // hold one request until accepted, then maybe idle for a while
    task automatic send_request(chm_pkg::t_req q);
        i_req_valid <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (o_req_stall);
        sb.note(q);
        requests_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_op(logic [1:0] kind, logic [31:0] key, logic [31:0] value,
                           logic [chm_pkg::LIM_W-1:0] limit);
        chm_pkg::t_req q;
        q.kind = kind;
        q.key = key;
        q.value = value;
        q.report_limit = limit;
        send_request(q);
    endtask

    // sender pauses until every awaited result is back, then lets the block settle
    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // bucket count may only change with the block idle
    task automatic write_buckets(logic [chm_pkg::LIM_W-1:0] n);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        sb.set_buckets(n);
        i_cfg_we <= 1'b0;
    endtask

    function automatic chm_pkg::t_req random_request();
        chm_pkg::t_req q;
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) q.kind = chm_pkg::K_INSERT;
        else if (roll < 80) q.kind = chm_pkg::K_LOOKUP;
        else if (roll < 95) q.kind = chm_pkg::K_ERASE;
        else q.kind = K_NONE;
        // mostly hot keys, some cold ones to miss
        q.key = ($urandom_range(9) < 8) ? hot_keys[$urandom_range(11)] : $urandom;
        q.value = $urandom;
        roll = $urandom_range(9);
        if (roll == 0) q.report_limit = '0;
        else if (roll == 1) q.report_limit = chm_pkg::LIM_W'($urandom_range(64, 127));
        else q.report_limit = chm_pkg::LIM_W'($urandom_range(1, 8));
        return q;
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (count) send_request(random_request());
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_req_valid <= 1'b0;
        i_req <= '0;
        i_rsp_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        foreach (hot_keys[i]) hot_keys[i] = $urandom;
        hot_keys[0] = 32'h0000_0000;
        hot_keys[1] = 32'hffff_ffff;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: key and value extremes, every kind, limit clamps, misses
        send_op(chm_pkg::K_INSERT, 32'h0000_0000, 32'h0000_0000, 7'd1);
        send_op(chm_pkg::K_INSERT, 32'hffff_ffff, 32'hffff_ffff, 7'd127);
        send_op(chm_pkg::K_INSERT, 32'h0000_0000, 32'h5a5a_a5a5, 7'd0);
        send_op(chm_pkg::K_INSERT, 32'h0000_0000, 32'ha5a5_5a5a, 7'd1);
        send_op(chm_pkg::K_LOOKUP, 32'h0000_0000, 32'h0, 7'd0);
        send_op(chm_pkg::K_LOOKUP, 32'h0000_0000, 32'h0, 7'd127);
        send_op(chm_pkg::K_LOOKUP, 32'h0000_0000, 32'h0, 7'd2);
        send_op(chm_pkg::K_LOOKUP, 32'hffff_ffff, 32'h0, 7'd64);
        send_op(chm_pkg::K_LOOKUP, 32'h1234_5678, 32'h0, 7'd5);
        send_op(chm_pkg::K_ERASE, 32'h0000_0000, 32'h0, 7'd1);
        send_op(chm_pkg::K_LOOKUP, 32'h0000_0000, 32'h0, 7'd4);
        send_op(chm_pkg::K_ERASE, 32'h1234_5678, 32'hffff_ffff, 7'd0);
        send_op(K_NONE, 32'hffff_ffff, 32'hffff_ffff, 7'd127);
        send_op(K_NONE, 32'h0, 32'h0, 7'd0);
        send_op(chm_pkg::K_INSERT, 32'h0000_0000, 32'h0000_0001, 7'd3);
        send_op(chm_pkg::K_LOOKUP, 32'h0000_0000, 32'h0, 7'd3);

        // one bucket: every key shares a chain
        write_buckets(7'd1);
        random_phase(40, 0, 0);
        // zero reads as one
        write_buckets(7'd0);
        random_phase(50, 75, 0);
        // above the maximum saturates, old nodes may become unreachable
        write_buckets(7'd127);
        random_phase(70, 0, 75);
        write_buckets(7'd7);
        random_phase(70, 9, 9);
        write_buckets(7'd64);
        random_phase(70, 0, 0);
        write_buckets(7'd42);
        random_phase(70, 75, 75);

        // long report, then empty the hot keys again
        write_buckets(7'd64);
        send_idle_pct = 0;
        rsp_stall_pct = 9;
        send_op(chm_pkg::K_LOOKUP, hot_keys[2], 32'h0, 7'd127);
        foreach (hot_keys[i]) send_op(chm_pkg::K_ERASE, hot_keys[i], 32'h0, 7'd1);
        random_phase(20, 0, 0);

        drain();
        $display("%0d requests and %0d results checked, %0d values reported",
                 requests_sent, sb.results_seen, sb.reported_values);
        $display("%0d inserts refused on a full pool, %0d nodes erased",
                 sb.refusals, sb.erased_total);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/chm_pkg.sv
design/chm_hash.sv
design/chained_hash_multimap.sv
design/chm_checker.sv
sim/tb_chained_hash_multimap.sv
